/* hw/rtl/lsbbp_pkg.sv */
// Shared types and constants of the LSB-first bit packer.
`default_nettype none

package lsbbp_pkg;

	localparam int CODE_W            = 16;
	localparam int LEN_W             = 5;
	localparam int PEND_W            = 7;
	localparam int PCNT_W            = 3;
	localparam int ACC_W             = 24;
	localparam int NBYTES_W          = 2;
	localparam int MAX_CODE_BITS_DEF = 16;
	localparam int QUEUE_DEPTH       = 4;

	// one packed job: gathered bits and how many bytes leave from them
	typedef struct packed {
		logic [ACC_W-1:0]    acc;
		logic [NBYTES_W-1:0] nbytes;
		logic                last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

/* hw/rtl/lsb_first_bit_packer_unit.sv */
// Top level of the LSB-first variable-length bit packer.
//
//  channel  | dir | fields (tdata / tuser / tlast)
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tdata: code_value[15:0], code_length[20:16]; tuser: flush
//  m_axis   | out | tdata: out_byte[7:0]; tlast: end_of_stream
//
// Each input transfer is taken while the job queue has room; its bytes (zero
// to three) then leave one per cycle from the output register while m_tready
// is high, so the byte-wide output port sets the sustained rate. Reset clears
// the pending bits, queue pointers and output valid. A stall on the output fills
// the queue, after which s_tready drops; items that produce no byte still need a
// free queue slot to be taken.
`default_nettype none

module lsb_first_bit_packer_unit
	import lsbbp_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // code_value[15:0], code_length[20:16], zero pad
	input  wire logic        s_tuser,   // flush_request
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tlast    // end_of_stream
);

	job_t      job;
	job_t      head;
	q_status_t qstat;
	logic      push;
	logic      pop;
	logic      unused_pad;

	// pad bits of the input word carry nothing
	assign unused_pad = ^s_tdata[23:21];

	lsbbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.code_value   (s_tdata[15:0]),
		.code_length  (s_tdata[20:16]),
		.flush_request(s_tuser),
		.in_ready     (s_tready),
		.qstat        (qstat),
		.push         (push),
		.job          (job)
	);

	// hold byte jobs so the front keeps accepting while the output stalls
	lsbbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(job),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	// advance through each job one byte per output transfer
	lsbbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte (m_tdata),
		.out_last (m_tlast)
	);

endmodule

`default_nettype wire

/* hw/rtl/lsbbp_front.sv */
// Front end: accept codes, merge with pending bits, build byte jobs.
`default_nettype none

module lsbbp_front
	import lsbbp_pkg::*;
#(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [CODE_W-1:0] code_value,
	input  wire logic [LEN_W-1:0]  code_length,
	input  wire logic              flush_request,
	output logic                   in_ready,
	input  wire q_status_t         qstat,
	output logic                   push,
	output job_t                   job
);

	localparam int CapBits = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CapBits);

	logic [PEND_W-1:0]   pending_q;
	logic [PCNT_W-1:0]   pcount_q;
	logic [LEN_W-1:0]    len;
	logic [CODE_W-1:0]   code;
	logic [ACC_W-1:0]    acc;
	logic [LEN_W-1:0]    count;
	logic [NBYTES_W-1:0] nfull;
	logic                rem_nz;
	logic [NBYTES_W-1:0] nbytes;
	logic [PEND_W-1:0]   pending_d;
	logic                accept;

	always_comb begin
		len    = (code_length > CAP_LEN) ? CAP_LEN : code_length;
		code   = code_value & ~({CODE_W{1'b1}} << len);
		acc    = {{(ACC_W-PEND_W){1'b0}}, pending_q}
		       | ({{(ACC_W-CODE_W){1'b0}}, code} << pcount_q);
		count  = {{(LEN_W-PCNT_W){1'b0}}, pcount_q} + len;
		nfull  = count[LEN_W-1:3];
		rem_nz = |count[2:0];
		if (!flush_request) begin
			nbytes = nfull;
		end else if (rem_nz) begin
			nbytes = nfull + 2'd1;
		end else if (nfull == 2'd0) begin
			nbytes = 2'd1;
		end else begin
			nbytes = nfull;
		end
		// leftover bits start right after the last full byte
		case (nfull)
			2'd0:    pending_d = acc[6:0];
			2'd1:    pending_d = acc[14:8];
			2'd2:    pending_d = acc[22:16];
			default: pending_d = '0;
		endcase
	end

	assign in_ready   = !qstat.full;
	assign accept     = in_valid && in_ready;
	assign push       = accept && (nbytes != '0);
	assign job.acc    = acc;
	assign job.nbytes = nbytes;
	assign job.last   = flush_request;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pcount_q  <= '0;
		end else if (accept) begin
			pending_q <= flush_request ? '0 : pending_d;
			pcount_q  <= flush_request ? '0 : count[PCNT_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lsbbp_queue.sv */
// Short job queue between front and back ends.
`default_nettype none

module lsbbp_queue
	import lsbbp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_status_t qstat
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CntW-1:0] DEPTH_C = CntW'(QUEUE_DEPTH);
	localparam logic [PtrW-1:0] LAST_PTR = PtrW'(QUEUE_DEPTH - 1);

	job_t            slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] cnt_q;

	assign head        = slot_q[rptr_q];
	assign qstat.full  = (cnt_q == DEPTH_C);
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("push into full job queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from empty job queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C) else $error("job queue count overrun");

endmodule

`default_nettype wire

/* hw/rtl/lsbbp_back.sv */
// Back end: send the bytes of each job through the output register.
`default_nettype none

module lsbbp_back
	import lsbbp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire job_t      head,
	input  wire q_status_t qstat,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [7:0]     out_byte,
	output logic           out_last
);

	logic [NBYTES_W-1:0] idx_q;
	logic                valid_q;
	logic [7:0]          byte_q;
	logic                last_q;
	logic                load;
	logic                last_byte;
	logic [7:0]          sel_byte;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.acc[7:0];
			2'd1:    sel_byte = head.acc[15:8];
			2'd2:    sel_byte = head.acc[23:16];
			default: sel_byte = '0;
		endcase
	end

	assign load      = (!valid_q || out_ready) && !qstat.empty;
	assign last_byte = (idx_q == head.nbytes - 2'd1);
	assign pop       = load && last_byte;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= head.last && last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last_byte ? '0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_mid_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != '0) |-> !qstat.empty) else $error("job left queue mid-way");

endmodule

`default_nettype wire
